// ===== rtl/core/dcc_pkg.sv =====
// Shared types, constants and the sequencer microprogram for the DCC bit encoder.
package dcc_pkg;

    localparam int US_W     = 10;
    localparam int TICK_W   = 16;
    localparam int STEP_W   = 4;
    localparam int PRE_W    = 5;
    localparam int BITCNT_W = 4;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_BIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_S1_PERIOD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_S1_HIGH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_S2_PERIOD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_S2_HIGH     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE    = 3'd7;

    // register reset values
    localparam logic [US_W-1:0]  RST_ONE_BIT   = 10'd116;
    localparam logic [US_W-1:0]  RST_ZERO_BIT  = 10'd200;
    localparam logic [US_W-1:0]  RST_ZERO_HIGH = 10'd100;
    localparam logic [US_W-1:0]  RST_S1_PERIOD = 10'd200;
    localparam logic [US_W-1:0]  RST_S1_HIGH   = 10'd100;
    localparam logic [US_W-1:0]  RST_S2_PERIOD = 10'd200;
    localparam logic [US_W-1:0]  RST_S2_HIGH   = 10'd100;
    localparam logic [PRE_W-1:0] RST_PREAMBLE  = 5'd18;

    localparam logic [PRE_W-1:0]    MAX_PREAMBLE = 5'd30;
    localparam logic [BITCNT_W-1:0] BYTE_BITS    = 4'd8;

    // packet modes
    localparam logic [1:0] FUNC_PREAMBLE = 2'd0;
    localparam logic [1:0] FUNC_BYTES    = 2'd1;
    localparam logic [1:0] FUNC_STRETCH1 = 2'd2;
    localparam logic [1:0] FUNC_STRETCH2 = 2'd3;

    // microprogram step addresses
    localparam logic [STEP_W-1:0] ST_WAIT    = 4'd0;
    localparam logic [STEP_W-1:0] ST_CHK_PRE = 4'd1;
    localparam logic [STEP_W-1:0] ST_CHK_CNT = 4'd2;
    localparam logic [STEP_W-1:0] ST_PRE     = 4'd3;
    localparam logic [STEP_W-1:0] ST_START   = 4'd4;
    localparam logic [STEP_W-1:0] ST_CHK_STR = 4'd5;
    localparam logic [STEP_W-1:0] ST_STR1    = 4'd6;
    localparam logic [STEP_W-1:0] ST_STR2    = 4'd7;
    localparam logic [STEP_W-1:0] ST_DATA    = 4'd8;
    localparam logic [STEP_W-1:0] ST_SEP     = 4'd9;

    // what a step puts out
    typedef enum logic [2:0] {
        E_NONE,
        E_ONE,
        E_ZERO,
        E_S1,
        E_S2,
        E_DATA,
        E_SEP
    } t_emit;

    // jump conditions; a taken jump loads the target, else the step advances
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_NO_PRE,
        C_CNT_ZERO,
        C_CNT_MORE,
        C_NOT_STRETCH,
        C_NOT_MODE3
    } t_cond;

    typedef struct packed {
        t_emit             emit;
        t_cond             cond;
        logic [STEP_W-1:0] target;
        logic              shift;    // drop the sent data bit
        logic              dec_pre;  // count one preamble bit
        logic              loop;     // data loop: jump back while bits remain
    } t_uword;

    // microprogram ROM
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{emit: E_NONE, cond: C_ALWAYS, target: ST_WAIT,
              shift: 1'b0, dec_pre: 1'b0, loop: 1'b0};
        case (step)
            ST_WAIT: begin
                w.cond = C_NO_INPUT; w.target = ST_WAIT;
            end
            ST_CHK_PRE: begin
                w.cond = C_NO_PRE; w.target = ST_CHK_STR;
            end
            ST_CHK_CNT: begin
                w.cond = C_CNT_ZERO; w.target = ST_START;
            end
            ST_PRE: begin
                w.emit = E_ONE; w.dec_pre = 1'b1;
                w.cond = C_CNT_MORE; w.target = ST_PRE;
            end
            ST_START: begin
                w.emit = E_ZERO; w.cond = C_NEVER;
            end
            ST_CHK_STR: begin
                w.cond = C_NOT_STRETCH; w.target = ST_DATA;
            end
            ST_STR1: begin
                w.emit = E_S1; w.shift = 1'b1;
                w.cond = C_NOT_MODE3; w.target = ST_DATA;
            end
            ST_STR2: begin
                w.emit = E_S2; w.shift = 1'b1; w.cond = C_NEVER;
            end
            ST_DATA: begin
                w.emit = E_DATA; w.shift = 1'b1; w.loop = 1'b1;
                w.cond = C_NEVER; w.target = ST_DATA;
            end
            ST_SEP: begin
                w.emit = E_SEP; w.cond = C_ALWAYS; w.target = ST_WAIT;
            end
            default: begin
                w.cond = C_ALWAYS; w.target = ST_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/dcc_packet_bit_encoder.sv =====
// DCC packet bit encoder: microcoded expansion of packet bytes into timed bit patterns.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_func, i_data_byte, i_first_of_packet,
//          |           |                           | i_last_of_packet
//  out     | output    | o_out_valid / i_out_ready | o_period_ticks, o_high_ticks, o_is_last
//  cfg     | input     | i_cfg_wr_en               | i_cfg_addr, i_cfg_data
//
//  One microprogram step runs per cycle. A step that emits a bit pattern waits while the
//  output register is full and not being taken. An item takes one accept step plus one
//  step per bit pattern plus two or three decision steps, and a packet opener sends up
//  to 30 preamble bits. The sequencer walks one item at a time; the next item is taken
//  once the previous separator has been loaded.
//  Reset (synchronous, active low) returns the step counter to the wait step, empties
//  the output register and loads the register defaults.
module dcc_packet_bit_encoder #(
    parameter int TICKS_PER_US = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_of_packet,
    input  logic        i_last_of_packet,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_period_ticks,
    output logic [15:0] o_high_ticks,
    output logic        o_is_last,

    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [9:0]  i_cfg_data
);

    // product width: microseconds times ticks, never narrower than a saturation test needs
    localparam int MUL_W  = dcc_pkg::US_W + $clog2(TICKS_PER_US + 1);
    localparam int PROD_W = (MUL_W > dcc_pkg::TICK_W + 1) ? MUL_W : dcc_pkg::TICK_W + 1;
    localparam logic [PROD_W-1:0] TICK_MAX = PROD_W'({dcc_pkg::TICK_W{1'b1}});
    localparam logic [PROD_W-1:0] TPU      = PROD_W'(TICKS_PER_US);

    // pattern kinds after resolving data and separator emits
    typedef enum logic [1:0] {
        P_ONE,
        P_ZERO,
        P_S1,
        P_S2
    } t_pat;

    // configuration registers
    logic [dcc_pkg::US_W-1:0]  r_one_bit_us;
    logic [dcc_pkg::US_W-1:0]  r_zero_bit_us;
    logic [dcc_pkg::US_W-1:0]  r_zero_high_us;
    logic [dcc_pkg::US_W-1:0]  r_s1_period_us;
    logic [dcc_pkg::US_W-1:0]  r_s1_high_us;
    logic [dcc_pkg::US_W-1:0]  r_s2_period_us;
    logic [dcc_pkg::US_W-1:0]  r_s2_high_us;
    logic [dcc_pkg::PRE_W-1:0] r_preamble_bits;

    // sequencer and item state
    logic [dcc_pkg::STEP_W-1:0]   r_step;
    logic [dcc_pkg::STEP_W-1:0]   n_step;
    logic [1:0]                   r_func;
    logic [7:0]                   r_byte;
    logic                         r_first;
    logic                         r_last;
    logic [dcc_pkg::PRE_W-1:0]    r_pre_cnt;
    logic [dcc_pkg::BITCNT_W-1:0] r_bits;

    // output register
    logic        r_out_valid;
    logic [15:0] r_period;
    logic [15:0] r_high;
    logic        r_is_last;

    dcc_pkg::t_uword uw;
    t_pat            pat;
    logic            in_xfer;
    logic            out_free;
    logic            emits;
    logic            go;
    logic            take;
    logic            stretch;
    logic [dcc_pkg::US_W-1:0]  per_us;
    logic [dcc_pkg::US_W-1:0]  hi_us;
    logic [PROD_W-1:0]         per_prod;
    logic [PROD_W-1:0]         hi_prod;
    logic [15:0]               per_sat;
    logic [15:0]               hi_sat;
    logic [15:0]               n_period;
    logic [15:0]               n_high;
    logic                      n_is_last;
    logic [dcc_pkg::PRE_W-1:0] pre_load;

    assign uw       = dcc_pkg::ucode(r_step);
    assign o_in_ready = (r_step == dcc_pkg::ST_WAIT);
    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign emits    = (uw.emit != dcc_pkg::E_NONE);
    // hold the step while its pattern cannot be loaded
    assign go       = !emits || out_free;
    assign stretch  = r_func[1];

    // clamp the preamble count to the supported maximum
    assign pre_load = (r_preamble_bits > dcc_pkg::MAX_PREAMBLE) ? dcc_pkg::MAX_PREAMBLE
                                                                : r_preamble_bits;

    // resolve the emit code to a pattern kind
    always_comb begin
        case (uw.emit)
            dcc_pkg::E_ONE:  pat = P_ONE;
            dcc_pkg::E_ZERO: pat = P_ZERO;
            dcc_pkg::E_S1:   pat = P_S1;
            dcc_pkg::E_S2:   pat = P_S2;
            dcc_pkg::E_DATA: pat = r_byte[0] ? P_ONE : P_ZERO;
            dcc_pkg::E_SEP:  pat = stretch ? P_S1 : P_ZERO;
            default:         pat = P_ZERO;
        endcase
    end

    // pick the configured times for the pattern
    always_comb begin
        case (pat)
            P_ONE:   begin per_us = r_one_bit_us;   hi_us = r_one_bit_us;   end
            P_ZERO:  begin per_us = r_zero_bit_us;  hi_us = r_zero_high_us; end
            P_S1:    begin per_us = r_s1_period_us; hi_us = r_s1_high_us;   end
            P_S2:    begin per_us = r_s2_period_us; hi_us = r_s2_high_us;   end
            default: begin per_us = r_zero_bit_us;  hi_us = r_zero_high_us; end
        endcase
    end

    // scale to ticks and saturate at the 16-bit limit
    assign per_prod = PROD_W'(per_us) * TPU;
    assign hi_prod  = PROD_W'(hi_us) * TPU;
    assign per_sat  = (per_prod > TICK_MAX) ? 16'hFFFF : per_prod[15:0];
    assign hi_sat   = (hi_prod > TICK_MAX) ? 16'hFFFF : hi_prod[15:0];

    // a one bit is high for half its saturated period
    assign n_period  = per_sat;
    assign n_high    = (pat == P_ONE) ? {1'b0, per_sat[15:1]} : hi_sat;
    assign n_is_last = (uw.emit == dcc_pkg::E_SEP) && r_last;

    // evaluate the step's jump condition
    always_comb begin
        case (uw.cond)
            dcc_pkg::C_NEVER:       take = 1'b0;
            dcc_pkg::C_ALWAYS:      take = 1'b1;
            dcc_pkg::C_NO_INPUT:    take = !in_xfer;
            dcc_pkg::C_NO_PRE:      take = !((r_func == dcc_pkg::FUNC_PREAMBLE) && r_first);
            dcc_pkg::C_CNT_ZERO:    take = (r_pre_cnt == '0);
            dcc_pkg::C_CNT_MORE:    take = (r_pre_cnt > dcc_pkg::PRE_W'(1));
            dcc_pkg::C_NOT_STRETCH: take = !stretch;
            dcc_pkg::C_NOT_MODE3:   take = (r_func != dcc_pkg::FUNC_STRETCH2);
            default:                take = 1'b0;
        endcase
        // the data step loops while more than the current bit is left
        if (uw.loop) begin
            take = (r_bits > dcc_pkg::BITCNT_W'(1));
        end
        n_step = take ? uw.target : r_step + dcc_pkg::STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step          <= dcc_pkg::ST_WAIT;
            r_out_valid     <= 1'b0;
            r_one_bit_us    <= dcc_pkg::RST_ONE_BIT;
            r_zero_bit_us   <= dcc_pkg::RST_ZERO_BIT;
            r_zero_high_us  <= dcc_pkg::RST_ZERO_HIGH;
            r_s1_period_us  <= dcc_pkg::RST_S1_PERIOD;
            r_s1_high_us    <= dcc_pkg::RST_S1_HIGH;
            r_s2_period_us  <= dcc_pkg::RST_S2_PERIOD;
            r_s2_high_us    <= dcc_pkg::RST_S2_HIGH;
            r_preamble_bits <= dcc_pkg::RST_PREAMBLE;
        end else begin
            // configuration writes
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    dcc_pkg::CFG_ONE_BIT:   r_one_bit_us    <= i_cfg_data;
                    dcc_pkg::CFG_ZERO_BIT:  r_zero_bit_us   <= i_cfg_data;
                    dcc_pkg::CFG_ZERO_HIGH: r_zero_high_us  <= i_cfg_data;
                    dcc_pkg::CFG_S1_PERIOD: r_s1_period_us  <= i_cfg_data;
                    dcc_pkg::CFG_S1_HIGH:   r_s1_high_us    <= i_cfg_data;
                    dcc_pkg::CFG_S2_PERIOD: r_s2_period_us  <= i_cfg_data;
                    dcc_pkg::CFG_S2_HIGH:   r_s2_high_us    <= i_cfg_data;
                    dcc_pkg::CFG_PREAMBLE:  r_preamble_bits <= i_cfg_data[dcc_pkg::PRE_W-1:0];
                    default: ;
                endcase
            end

            // load a new result, else drop the delivered one
            if (go && emits) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // capture a new item
            if (in_xfer) begin
                r_func    <= i_func;
                r_byte    <= i_data_byte;
                r_first   <= i_first_of_packet;
                r_last    <= i_last_of_packet;
                r_pre_cnt <= pre_load;
                r_bits    <= dcc_pkg::BYTE_BITS;
            end

            if (go) begin
                r_step <= n_step;
                if (emits) begin
                    r_period    <= n_period;
                    r_high      <= n_high;
                    r_is_last   <= n_is_last;
                end
                if (uw.shift) begin
                    r_byte <= {1'b0, r_byte[7:1]};
                    r_bits <= r_bits - dcc_pkg::BITCNT_W'(1);
                end
                if (uw.dec_pre) begin
                    r_pre_cnt <= r_pre_cnt - dcc_pkg::PRE_W'(1);
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_period_ticks = r_period;
    assign o_high_ticks   = r_high;
    assign o_is_last      = r_is_last;

    // an accepted item always moves the sequencer off the wait step
    a_accept_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_step == dcc_pkg::ST_CHK_PRE))
        else $error("sequencer did not leave wait step after input transfer");

    // the data loop never runs with its bit count spent
    a_data_bits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == dcc_pkg::ST_DATA) |-> (r_bits != '0))
        else $error("data step entered with no bits left");

    // a preamble bit is only sent while the count is nonzero
    a_pre_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == dcc_pkg::ST_PRE) |-> (r_pre_cnt != '0))
        else $error("preamble step entered with empty count");

    // once the separator is loaded the sequencer is back waiting for input
    a_sep_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == dcc_pkg::ST_SEP) && go) |=> (r_step == dcc_pkg::ST_WAIT))
        else $error("separator step did not return to wait");

endmodule

// ===== tb/dcc_packet_bit_encoder_tb.sv =====
// Self-checking testbench for the DCC packet bit encoder: random traffic, scoreboard, stalls.
module dcc_packet_bit_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICKS           = 16;
    localparam int CLK_PERIOD      = 10;
    localparam int HOLD_OFF_CYCLES = 400;   // long receiver hold-off, fills the block
    localparam int SETTLE_CYCLES   = 60;    // a little over the longest item (44 steps)
    localparam int TIMEOUT_CYCLES  = 1_000_000;
    localparam int RANDOM_PHASES   = 4;
    localparam int ITEMS_PER_PHASE = 20;
    localparam int REPORT_LIMIT    = 10;

    // One bit pattern on the output channel.
    typedef struct packed {
        logic [15:0] period;
        logic [15:0] high;
        logic        is_last;
    } t_pattern;

    // Shadow registers, pattern predictor and queue of patterns still owed by the block.
    class bit_pattern_board;
        logic [9:0] one_us, zero_us, zero_high_us;
        logic [9:0] s1_period_us, s1_high_us, s2_period_us, s2_high_us;
        logic [4:0] preamble;
        t_pattern   owed_q[$];
        int         mismatches = 0;

        function void load_defaults();
            one_us       = dcc_pkg::RST_ONE_BIT;
            zero_us      = dcc_pkg::RST_ZERO_BIT;
            zero_high_us = dcc_pkg::RST_ZERO_HIGH;
            s1_period_us = dcc_pkg::RST_S1_PERIOD;
            s1_high_us   = dcc_pkg::RST_S1_HIGH;
            s2_period_us = dcc_pkg::RST_S2_PERIOD;
            s2_high_us   = dcc_pkg::RST_S2_HIGH;
            preamble     = dcc_pkg::RST_PREAMBLE;
        endfunction

        function void set_reg(logic [2:0] idx, logic [9:0] val);
            case (idx)
                dcc_pkg::CFG_ONE_BIT:   one_us       = val;
                dcc_pkg::CFG_ZERO_BIT:  zero_us      = val;
                dcc_pkg::CFG_ZERO_HIGH: zero_high_us = val;
                dcc_pkg::CFG_S1_PERIOD: s1_period_us = val;
                dcc_pkg::CFG_S1_HIGH:   s1_high_us   = val;
                dcc_pkg::CFG_S2_PERIOD: s2_period_us = val;
                dcc_pkg::CFG_S2_HIGH:   s2_high_us   = val;
                dcc_pkg::CFG_PREAMBLE:  preamble     = val[4:0];
                default: ;
            endcase
        endfunction

        // Scale microseconds to ticks, saturating at 16 bits.
        function logic [15:0] to_ticks(logic [9:0] us);
            int unsigned t;
            t = 32'(us) * TICKS;
            if (t > 32'hFFFF)
                return 16'hFFFF;
            return t[15:0];
        endfunction

        function void owe(logic [15:0] period, logic [15:0] high, logic is_last);
            t_pattern p;
            p.period  = period;
            p.high    = high;
            p.is_last = is_last;
            owed_q.push_back(p);
        endfunction

        // Expand one accepted packet byte into the bit patterns it must produce.
        function void note_item(logic [1:0] func, logic [7:0] data, logic opens, logic closes);
            logic [15:0] p1, h1, p0, h0, ps1, hs1, ps2, hs2;
            int          cnt, lo, i, b;
            p1  = to_ticks(one_us);
            h1  = p1 >> 1;
            p0  = to_ticks(zero_us);
            h0  = to_ticks(zero_high_us);
            ps1 = to_ticks(s1_period_us);
            hs1 = to_ticks(s1_high_us);
            ps2 = to_ticks(s2_period_us);
            hs2 = to_ticks(s2_high_us);
            lo  = 0;
            // the opener mark only matters in preamble mode; a count of 31 acts as 30
            if (func == dcc_pkg::FUNC_PREAMBLE && opens) begin
                cnt = (preamble > dcc_pkg::MAX_PREAMBLE) ? int'(dcc_pkg::MAX_PREAMBLE)
                                                         : int'(preamble);
                for (i = 0; i < cnt; i++)
                    owe(p1, h1, 1'b0);
                owe(p0, h0, 1'b0);
            end
            if (func == dcc_pkg::FUNC_STRETCH1 || func == dcc_pkg::FUNC_STRETCH2) begin
                owe(ps1, hs1, 1'b0);
                lo = 1;
                if (func == dcc_pkg::FUNC_STRETCH2) begin
                    owe(ps2, hs2, 1'b0);
                    lo = 2;
                end
            end
            for (b = lo; b < 8; b++) begin
                if (data[b])
                    owe(p1, h1, 1'b0);
                else
                    owe(p0, h0, 1'b0);
            end
            if (func == dcc_pkg::FUNC_STRETCH1 || func == dcc_pkg::FUNC_STRETCH2)
                owe(ps1, hs1, closes);
            else
                owe(p0, h0, closes);
        endfunction

        function void check_result(logic [15:0] period, logic [15:0] high, logic is_last);
            t_pattern want;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected pattern period=%0d high=%0d is_last=%0b",
                             $realtime, period, high, is_last);
                return;
            end
            want = owed_q.pop_front();
            if (want.period !== period || want.high !== high || want.is_last !== is_last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: pattern differs: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                             $realtime, want.period, want.high, want.is_last,
                             period, high, is_last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_func;
    logic [7:0]  i_data_byte;
    logic        i_first_of_packet;
    logic        i_last_of_packet;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_period_ticks;
    logic [15:0] o_high_ticks;
    logic        o_is_last;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_addr;
    logic [9:0]  i_cfg_data;

    bit_pattern_board sb;
    int  items_sent  = 0;
    bit  sender_calm = 1'b0;   // sender offers back to back
    bit  rx_calm     = 1'b0;   // receiver never stalls
    bit  hold_req    = 1'b0;   // ask the receiver for one long hold-off

    dcc_packet_bit_encoder #(.TICKS_PER_US(TICKS)) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_data_byte       (i_data_byte),
        .i_first_of_packet (i_first_of_packet),
        .i_last_of_packet  (i_last_of_packet),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_period_ticks    (o_period_ticks),
        .o_high_ticks      (o_high_ticks),
        .o_is_last         (o_is_last),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("end of test: mismatches");
        $finish;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Output side: check each transfer, then pick ready for the next edge.
    int hold_left  = 0;
    int stall_left = 0;
    bit hold_done  = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_period_ticks, o_high_ticks, o_is_last);
            // start the one long hold-off when asked
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (rx_calm || $urandom_range(0, 99) < 65) begin
                i_out_ready <= 1'b1;
            end else begin
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(8, 30);
                i_out_ready <= 1'b0;
            end
        end
    end

    // Offer one packet byte after a random gap, hold it until the transfer, then drop valid.
    task automatic send_item(input logic [1:0] func, input logic [7:0] data,
                             input logic opens, input logic closes);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        repeat (gap) @(posedge i_clk);
        i_in_valid        <= 1'b1;
        i_func            <= func;
        i_data_byte       <= data;
        i_first_of_packet <= opens;
        i_last_of_packet  <= closes;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_item(func, data, opens, closes);
        items_sent++;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Block until every owed pattern has come out.
    task automatic wait_drained();
        while (sb.owed_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Write all eight registers; the preamble write carries junk in its upper bits.
    task automatic write_config(input logic [9:0] one, input logic [9:0] zero,
                                input logic [9:0] zero_high, input logic [9:0] s1_period,
                                input logic [9:0] s1_high, input logic [9:0] s2_period,
                                input logic [9:0] s2_high, input logic [4:0] pre);
        write_reg(dcc_pkg::CFG_ONE_BIT, one);
        write_reg(dcc_pkg::CFG_ZERO_BIT, zero);
        write_reg(dcc_pkg::CFG_ZERO_HIGH, zero_high);
        write_reg(dcc_pkg::CFG_S1_PERIOD, s1_period);
        write_reg(dcc_pkg::CFG_S1_HIGH, s1_high);
        write_reg(dcc_pkg::CFG_S2_PERIOD, s2_period);
        write_reg(dcc_pkg::CFG_S2_HIGH, s2_high);
        write_reg(dcc_pkg::CFG_PREAMBLE, {5'($urandom_range(0, 31)), pre});
        i_cfg_wr_en <= 1'b0;
    endtask

    // Random time: a fair share at the extremes.
    function automatic logic [9:0] pick_us();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 10'd0;
        if (r == 1)
            return 10'd1023;
        return 10'($urandom_range(0, 1023));
    endfunction

    task automatic random_config();
        write_config(pick_us(), pick_us(), pick_us(), pick_us(), pick_us(), pick_us(),
                     pick_us(), 5'($urandom_range(0, 31)));
    endtask

    // A packet of one to five bytes: mostly well-formed, sometimes pure noise.
    task automatic send_packet(input bit noisy);
        int         n, r;
        logic [1:0] func;
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
            if (noisy) begin
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                r = $urandom_range(0, 99);
                if (k == 0)
                    func = (r < 60) ? dcc_pkg::FUNC_PREAMBLE : 2'($urandom_range(0, 3));
                else
                    func = (r < 75) ? dcc_pkg::FUNC_BYTES : 2'($urandom_range(0, 3));
                send_item(func, 8'($urandom_range(0, 255)), k == 0, k == n - 1);
            end
        end
    endtask

    initial begin
        int phase_end;
        sb = new;
        sb.load_defaults();
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_func            = dcc_pkg::FUNC_PREAMBLE;
        i_data_byte       = 8'h00;
        i_first_of_packet = 1'b0;
        i_last_of_packet  = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_addr        = dcc_pkg::CFG_ONE_BIT;
        i_cfg_data        = 10'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes at the reset timings: every mode, both marks, byte extremes.
        send_item(dcc_pkg::FUNC_PREAMBLE, 8'h00, 1'b1, 1'b0);
        send_item(dcc_pkg::FUNC_BYTES,    8'hFF, 1'b0, 1'b0);
        send_item(dcc_pkg::FUNC_BYTES,    8'hA5, 1'b0, 1'b1);
        send_item(dcc_pkg::FUNC_PREAMBLE, 8'h5A, 1'b0, 1'b0);   // no opener: no preamble
        send_item(dcc_pkg::FUNC_BYTES,    8'h01, 1'b1, 1'b1);   // opener mark ignored
        send_item(dcc_pkg::FUNC_STRETCH1, 8'h00, 1'b0, 1'b0);
        send_item(dcc_pkg::FUNC_STRETCH1, 8'hFF, 1'b1, 1'b1);
        send_item(dcc_pkg::FUNC_STRETCH2, 8'h00, 1'b0, 1'b0);
        send_item(dcc_pkg::FUNC_STRETCH2, 8'hFF, 1'b0, 1'b1);
        send_item(dcc_pkg::FUNC_STRETCH2, 8'h03, 1'b1, 1'b0);   // forced bits carry ones
        send_item(dcc_pkg::FUNC_STRETCH1, 8'h01, 1'b0, 1'b0);
        send_item(dcc_pkg::FUNC_PREAMBLE, 8'h80, 1'b1, 1'b1);
        wait_drained();

        // All times zero and no preamble: the start bit still goes out.
        write_config(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
        send_item(dcc_pkg::FUNC_PREAMBLE, 8'h6C, 1'b1, 1'b0);
        send_item(dcc_pkg::FUNC_BYTES,    8'h93, 1'b0, 1'b0);
        send_item(dcc_pkg::FUNC_STRETCH1, 8'h3E, 1'b0, 1'b0);
        send_item(dcc_pkg::FUNC_STRETCH2, 8'hC1, 1'b0, 1'b1);
        wait_drained();

        // Longest times, preamble count past its range (31 acts as 30).
        write_config(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                     10'd1023, 5'd31);
        send_item(dcc_pkg::FUNC_PREAMBLE, 8'hFF, 1'b1, 1'b1);
        send_item(dcc_pkg::FUNC_STRETCH2, 8'h55, 1'b0, 1'b1);
        wait_drained();

        write_config(10'd1, 10'd3, 10'd1, 10'd7, 10'd2, 10'd9, 10'd4, dcc_pkg::MAX_PREAMBLE);
        send_item(dcc_pkg::FUNC_PREAMBLE, 8'hAA, 1'b1, 1'b1);
        wait_drained();

        // Random phases, a fresh register set for each.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            random_config();
            sender_calm = (phase == 1) || (phase == 2);
            rx_calm     = (phase == 1);
            // hold the receiver off while the sender keeps pushing
            if (phase == 2)
                hold_req = 1'b1;
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end)
                send_packet($urandom_range(0, 99) < 15);
        end
        i_in_valid <= 1'b0;
        sender_calm = 1'b0;
        rx_calm     = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.owed_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dcc_pkg.sv
rtl/core/dcc_packet_bit_encoder.sv
tb/dcc_packet_bit_encoder_tb.sv
